FILE: rtl/i8rq_pkg.sv
// i8rq_pkg: request types and register indexes for the int8 requantizer
// used by int8_requantizer_unit and its checker; no dependencies
package i8rq_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_SIGNED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USPAN_X2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SSPAN_X2 = 3'd4;

  typedef struct packed {
    logic [7:0]         in_byte;
    logic               in_is_signed;
    logic signed [31:0] in_min;
    logic signed [31:0] in_max;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       saturated;
  } out_req_t;

endpackage

FILE: rtl/int8_requantizer_unit.sv
// int8_requantizer_unit: pipelined requantizer of quantized bytes between ranges
// depends on i8rq_pkg (request types, register indexes)
//
//  channel  | signals                        | direction
//  ---------+--------------------------------+----------
//  input    | in_valid, in_stall, in_data    | in
//  output   | out_valid, out_stall, res_data | out
//  config   | cfg_we, cfg_index, cfg_data    | in
//
// one request per cycle while the output is not stalled; the pipeline has 4 arithmetic stages,
// a divider setup stage, 9 one-bit restoring divider stages and the output register.
// each stage moves on when it is empty or the next one moves, so bubbles squeeze out.
// rst (synchronous) empties the pipeline and loads the register defaults.
module int8_requantizer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  i8rq_pkg::in_req_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output i8rq_pkg::out_req_t            res_data,
  input  logic                          cfg_we,
  input  logic [i8rq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i8rq_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NST = 15;
  localparam int DIV0 = 4;

  typedef struct packed {
    logic neg;
    logic ovf;
    logic ge;
    logic gt;
    logic pneg;
  } div_flags_t;

  // configuration registers
  logic signed [31:0] reg_out_min;
  logic signed [31:0] reg_out_max;
  logic               reg_out_signed;
  logic [9:0]         reg_uspan2;
  logic [8:0]         reg_sspan2;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_out_min    <= 32'sd0;
      reg_out_max    <= 32'sd65536;
      reg_out_signed <= 1'b0;
      reg_uspan2     <= 10'd511;
      reg_sspan2     <= 9'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i8rq_pkg::CFG_OUT_MIN:    reg_out_min    <= $signed(cfg_data);
        i8rq_pkg::CFG_OUT_MAX:    reg_out_max    <= $signed(cfg_data);
        i8rq_pkg::CFG_OUT_SIGNED: reg_out_signed <= cfg_data[0];
        i8rq_pkg::CFG_USPAN_X2:   reg_uspan2     <= cfg_data[9:0];
        i8rq_pkg::CFG_SSPAN_X2:   reg_sspan2     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // derived configuration; the user must keep it stable while requests are in flight (not enforced here)
  logic [9:0]         us2;
  logic [8:0]         ss2;
  logic signed [32:0] dout;
  logic               dpos;
  logic [32:0]        abs_omin;
  logic [32:0]        abs_omax;
  logic [31:0]        ao;
  logic [7:0]         lim;
  logic [9:0]         ss2_inc;
  logic [8:0]         half_s;

  assign us2 = (reg_uspan2 < 10'd2) ? 10'd2 : reg_uspan2;
  assign ss2 = (reg_sspan2 < 9'd2) ? 9'd2 : reg_sspan2;
  assign dout = 33'(reg_out_max) - 33'(reg_out_min);
  assign dpos = !dout[32] && (dout != 33'sd0);
  assign abs_omin = reg_out_min[31] ? 33'(-33'(reg_out_min)) : 33'(reg_out_min);
  assign abs_omax = reg_out_max[31] ? 33'(-33'(reg_out_max)) : 33'(reg_out_max);
  assign ao = (abs_omin > abs_omax) ? abs_omin[31:0] : abs_omax[31:0];
  assign lim = us2[9] ? 8'hFF : us2[8:1];
  assign ss2_inc = {1'b0, ss2} + 10'd1;
  assign half_s = ss2_inc[9:1];

  // valid bits and per-stage enables
  logic [NST-1:0] v;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 1: dequantization product
  logic signed [8:0]  mul_a;
  logic signed [33:0] in_dif;
  logic [33:0]        abs_imin;
  logic [33:0]        abs_imax;
  logic signed [33:0] in_a;
  logic signed [33:0] mul_b;
  logic signed [42:0] prod1_c;
  logic signed [42:0] prod2_full;
  logic signed [42:0] s1_prod1;
  logic signed [42:0] s1_prod2;
  logic [9:0]         s1_q;

  assign mul_a = in_data.in_is_signed ? $signed({in_data.in_byte[7], in_data.in_byte})
                                      : $signed({1'b0, in_data.in_byte});
  assign in_dif = 34'(in_data.in_max) - 34'(in_data.in_min);
  assign abs_imin = in_data.in_min[31] ? 34'(-34'(in_data.in_min)) : 34'(in_data.in_min);
  assign abs_imax = in_data.in_max[31] ? 34'(-34'(in_data.in_max)) : 34'(in_data.in_max);
  assign in_a = (abs_imin > abs_imax) ? $signed(abs_imin) : $signed(abs_imax);
  assign mul_b = in_data.in_is_signed ? in_a : in_dif;
  assign prod1_c = mul_a * mul_b;
  assign prod2_full = $signed({1'b0, us2}) * in_data.in_min;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_prod1 <= prod1_c;
      if (in_data.in_is_signed) begin
        s1_prod2 <= '0;
        s1_q     <= {1'b0, ss2};
      end else begin
        s1_prod2 <= prod2_full;
        s1_q     <= us2;
      end
    end
  end

  // stage 2: real value numerator and products of q with the output range
  logic signed [43:0] p_c;
  logic signed [42:0] qomin_c;
  logic signed [43:0] qdout_c;
  logic [41:0]        qao_c;
  logic signed [43:0] s2_p;
  logic signed [42:0] s2_qomin;
  logic signed [43:0] s2_qdout;
  logic [41:0]        s2_qao;

  assign p_c = $signed({s1_prod1, 1'b0}) + 44'(s1_prod2);
  assign qomin_c = $signed({1'b0, s1_q}) * reg_out_min;
  assign qdout_c = $signed({1'b0, s1_q}) * dout;
  assign qao_c = s1_q * ao;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_p     <= p_c;
      s2_qomin <= qomin_c;
      s2_qdout <= qdout_c;
      s2_qao   <= qao_c;
    end
  end

  // stage 3: offset, magnitude and range compare
  logic signed [44:0] t_c;
  logic [43:0]        ap_c;
  logic signed [44:0] s3_t;
  logic [43:0]        s3_ap;
  logic signed [43:0] s3_qdout;
  logic [41:0]        s3_qao;
  logic               s3_ge;
  logic               s3_gt;
  logic               s3_pneg;

  assign t_c = 45'(s2_p) - 45'(s2_qomin);
  assign ap_c = s2_p[43] ? 44'(-s2_p) : 44'(s2_p);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_t     <= t_c;
      s3_ap    <= ap_c;
      s3_qdout <= s2_qdout;
      s3_qao   <= s2_qao;
      s3_ge    <= ap_c >= {2'b0, s2_qao};
      s3_gt    <= ap_c > {2'b0, s2_qao};
      s3_pneg  <= s2_p[43];
    end
  end

  // stage 4: dividend and divisor
  logic signed [55:0] nu_mul;
  logic signed [56:0] nu_c;
  logic [52:0]        apss;
  logic [56:0]        ns_c;
  logic signed [56:0] n_c;
  logic [44:0]        d_c;
  logic signed [56:0] s4_n;
  logic [44:0]        s4_d;
  logic               s4_ge;
  logic               s4_gt;
  logic               s4_pneg;

  assign nu_mul = s3_t * $signed({1'b0, us2});
  assign nu_c = 57'(nu_mul) + 57'(s3_qdout);
  assign apss = s3_ap * ss2;
  assign ns_c = 57'(apss) + 57'(s3_qao);
  assign n_c = reg_out_signed ? $signed(ns_c) : nu_c;
  assign d_c = reg_out_signed ? {2'b0, s3_qao, 1'b0} : {s3_qdout, 1'b0};

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_n    <= n_c;
      s4_d    <= d_c;
      s4_ge   <= s3_ge;
      s4_gt   <= s3_gt;
      s4_pneg <= s3_pneg;
    end
  end

  // divider: setup stage then one quotient bit per stage
  logic [55:0]  dr [9];
  logic [8:0]   dq [10];
  logic [44:0]  dd [9];
  div_flags_t   df [10];

  always_ff @(posedge clk) begin
    if (en[DIV0]) begin
      dr[0] <= s4_n[55:0];
      dq[0] <= '0;
      dd[0] <= s4_d;
      df[0] <= '{neg: s4_n[56],
                 ovf: s4_n[55:0] >= ({11'b0, s4_d} << 9),
                 ge: s4_ge, gt: s4_gt, pneg: s4_pneg};
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_div
    logic [55:0] dsh;
    logic        take;

    assign dsh = {11'b0, dd[k]} << (8 - k);
    assign take = dr[k] >= dsh;

    always_ff @(posedge clk) begin
      if (en[DIV0+k+1]) begin
        dq[k+1] <= {dq[k][7:0], take};
        df[k+1] <= df[k];
      end
    end

    // the last bit stage needs no remainder
    if (k < 8) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[DIV0+k+1]) begin
          dr[k+1] <= take ? dr[k] - dsh : dr[k];
          dd[k+1] <= dd[k];
        end
      end
    end
  end

  // output stage: clamp and format
  logic [8:0]  qv;
  logic [8:0]  m_c;
  logic [7:0]  res_c;
  logic        sat_c;
  logic [7:0]  m8;

  assign qv = dq[9];

  always_comb begin
    res_c = '0;
    sat_c = 1'b0;
    m_c = '0;
    m8 = '0;
    if (!reg_out_signed) begin
      if (dpos) begin
        if (df[9].neg) begin
          sat_c = 1'b1;
        end else if (df[9].ovf || (qv > {1'b0, lim})) begin
          res_c = lim;
          sat_c = 1'b1;
        end else begin
          res_c = qv[7:0];
        end
      end
    end else if (ao != 32'd0) begin
      if (df[9].ge) begin
        m_c = half_s;
        sat_c = df[9].gt;
      end else begin
        m_c = qv;
      end
      if (m_c > 9'd127) begin
        m8 = 8'd127;
        sat_c = 1'b1;
      end else begin
        m8 = m_c[7:0];
      end
      res_c = df[9].pneg ? 8'(-m8) : m8;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      res_data.out_byte  <= res_c;
      res_data.saturated <= sat_c;
    end
  end

endmodule

FILE: rtl/i8rq_checker.sv
// i8rq_checker: port-level checks for int8_requantizer_unit, bound to it below
// depends on i8rq_pkg (request types)
module i8rq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input i8rq_pkg::in_req_t             in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input i8rq_pkg::out_req_t            res_data
);

  // a stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_data))
    else $error("stalled result dropped or changed");

  // a stalled request stays and holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request dropped or changed");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // an empty output register lets the whole pipeline move
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // input backpressure only comes from a held result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind int8_requantizer_unit i8rq_checker u_i8rq_checker (.*);
